FILE: hdl/ptd_pkg.sv
`default_nettype none
package ptd_pkg;

  // fixed widths of the channel fields
  localparam int CAND_WIDTH      = 32;
  localparam int ECHO_WIDTH      = 32;
  localparam int DEF_VALUE_WIDTH = 32;

  // smallest divisor tried and its square
  localparam int FIRST_DIVISOR   = 2;
  localparam int FIRST_SQUARE    = FIRST_DIVISOR * FIRST_DIVISOR;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_TEST,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic start_div;
    logic div_step;
    logic next_k;
    logic set_verdict;
    logic verdict;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic lt_two;
    logic sq_gt_v;
    logic div_last;
    logic rem_zero;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: hdl/ptd_in_if.sv
`default_nettype none
interface ptd_in_if;
  import ptd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CAND_WIDTH-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface
`default_nettype wire

FILE: hdl/ptd_out_if.sv
`default_nettype none
interface ptd_out_if;
  import ptd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  is_prime;
  logic [ECHO_WIDTH-1:0] echo_value;

  modport source (output valid, output is_prime, output echo_value, input ready);
  modport sink   (input valid, input is_prime, input echo_value, output ready);
endinterface
`default_nettype wire

FILE: hdl/ptd_datapath.sv
`default_nettype none
module ptd_datapath #(
  parameter int VALUE_WIDTH = ptd_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [ptd_pkg::CAND_WIDTH-1:0] candidate,
  input  wire ptd_pkg::cmd_t                 cmd,
  output ptd_pkg::sts_t                      sts,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_is_prime,
  output logic [ptd_pkg::ECHO_WIDTH-1:0]     out_echo_value
);
  import ptd_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int CW = $clog2(VW);

  logic [VW-1:0] v_r;
  logic [VW-1:0] k_r;
  logic [VW:0]   sq_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dq_r;
  logic [CW-1:0] cnt_r;
  logic          verdict_r;
  logic          out_valid_r;
  logic          out_prime_r;
  logic [ECHO_WIDTH-1:0] out_echo_r;

  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic [VW:0]   sq_nxt;

  // one shift-subtract step of the remainder
  assign trial  = {rem_r, dq_r[VW-1]};
  assign diff   = trial - {1'b0, k_r};
  // (k+1)^2 = k^2 + 2k + 1
  assign sq_nxt = sq_r + {k_r, 1'b1};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r  <= VW'(candidate);
      k_r  <= VW'(FIRST_DIVISOR);
      sq_r <= (VW + 1)'(FIRST_SQUARE);
    end
    if (cmd.start_div) begin
      rem_r <= '0;
      dq_r  <= v_r;
      cnt_r <= CW'(VW - 1);
    end else if (cmd.div_step) begin
      rem_r <= diff[VW] ? trial[VW-1:0] : diff[VW-1:0];
      dq_r  <= {dq_r[VW-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.next_k) begin
      k_r  <= k_r + 1'b1;
      sq_r <= sq_nxt;
    end
    if (cmd.set_verdict) begin
      verdict_r <= cmd.verdict;
    end
    if (cmd.out_load) begin
      out_prime_r <= verdict_r;
      out_echo_r  <= ECHO_WIDTH'(v_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    sts.lt_two   = (v_r < VW'(FIRST_DIVISOR));
    sts.sq_gt_v  = (sq_r > {1'b0, v_r});
    sts.div_last = (cnt_r == '0);
    sts.rem_zero = (rem_r == '0);
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid      = out_valid_r;
  assign out_is_prime   = out_prime_r;
  assign out_echo_value = out_echo_r;

endmodule
`default_nettype wire

FILE: hdl/ptd_ctrl.sv
`default_nettype none
module ptd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ptd_pkg::sts_t sts,
  output ptd_pkg::cmd_t      cmd
);
  import ptd_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.lt_two || sts.sq_gt_v) state_nxt = S_FINISH;
        else                           state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_last) state_nxt = S_TEST;
      end
      S_TEST: begin
        if (sts.rem_zero) state_nxt = S_FINISH;
        else              state_nxt = S_CHECK;
      end
      S_FINISH: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_CHECK: begin
        if (sts.lt_two) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = 1'b0;
        end else if (sts.sq_gt_v) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = 1'b1;
        end else begin
          cmd.start_div = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_TEST: begin
        if (sts.rem_zero) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = 1'b0;
        end else begin
          cmd.next_k = 1'b1;
        end
      end
      S_FINISH: begin
        cmd.out_load = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/prime_trial_division_test.sv
`default_nettype none
// Trial-division primality test. Each input transaction carries one unsigned
// candidate; its low VALUE_WIDTH bits are tested and one result transaction
// returns is_prime with the tested value in echo_value (0 and 1 are reported
// not prime, 2 and 3 prime). Divisors k = 2, 3, ... are tried while k*k does
// not exceed the value, and the search stops at the first exact divisor.
// k*k is kept by an incremental add, and each remainder comes from a
// shift-subtract unit that retires one bit per cycle; each divisor goes
// through a bound check, VALUE_WIDTH remainder steps and a test. At most
// floor(sqrt(value)) - 1 divisors are tried. The finish state waits while
// an earlier verdict still sits uncollected in the output register. One
// item is in work at a time; the result sits in an output register, so a
// new candidate is taken while the previous verdict still waits to be
// collected.
module prime_trial_division_test #(
  parameter int VALUE_WIDTH = ptd_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ptd_in_if.sink    in_ch,
  ptd_out_if.source out_ch
);
  import ptd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: accept, bound check, remainder, verdict
  ptd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // value, divisor, square and remainder registers plus output register
  ptd_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .candidate      (in_ch.candidate),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_is_prime   (out_ch.is_prime),
    .out_echo_value (out_ch.echo_value)
  );

  // a transaction starts a search, so the input closes on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input still open after accepting a candidate");

  // nothing below two is ever prime
  a_prime_at_least_two: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_prime |-> out_ch.echo_value >= ECHO_WIDTH'(2))
    else $error("value below two reported prime");

  // the only even prime is two
  a_even_prime: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_prime && !out_ch.echo_value[0]
      |-> out_ch.echo_value == ECHO_WIDTH'(2))
    else $error("even value other than two reported prime");

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ptd_pkg::*;

  // dut built at its default width; the predictor masks with the same value
  localparam int VALUE_WIDTH  = DEF_VALUE_WIDTH;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 80;
  localparam int PHASES       = 3;
  // random candidates whose search would try more divisors than this are
  // redrawn
  localparam int TRY_BUDGET   = 1024;
  // slowest run is roughly 100 transactions at the budget; allow several times that
  localparam int CYCLE_LIMIT  = 20_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int N_DIRECTED   = 21;

  typedef struct {
    logic                  is_prime;
    logic [ECHO_WIDTH-1:0] echo;
  } verdict_t;

  // one directed row; the verdict is typed in only where it is obvious
  typedef struct packed {
    logic [CAND_WIDTH-1:0] cand;
    logic                  typed;
    logic                  prime;
  } directed_row_t;

  logic clk;
  logic rst_n;

  ptd_in_if  in_ch ();
  ptd_out_if out_ch ();

  prime_trial_division_test #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  verdict_t    pending_verdicts[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int          src_idle_pct;
  int          snk_idle_pct;

  directed_row_t directed_rows [N_DIRECTED] = '{
    // zero and one are not prime
    '{32'h0000_0000, 1'b1, 1'b0},
    '{32'h0000_0001, 1'b1, 1'b0},
    // two and three: no divisor tried, reported prime
    '{32'h0000_0002, 1'b1, 1'b1},
    '{32'h0000_0003, 1'b1, 1'b1},
    // first square, stops on the very first divisor
    '{32'h0000_0004, 1'b1, 1'b0},
    // field extremes and even wide values
    '{32'hFFFF_FFFF, 1'b1, 1'b0},
    '{32'h8000_0000, 1'b1, 1'b0},
    '{32'hFFFF_FFFE, 1'b1, 1'b0},
    '{32'hAAAA_AAAA, 1'b1, 1'b0},
    '{32'h5555_5555, 1'b0, 1'b0},
    // small primes and squares, bound k*k == value hit exactly
    '{32'd5,         1'b0, 1'b0},
    '{32'd9,         1'b0, 1'b0},
    '{32'd25,        1'b0, 1'b0},
    '{32'd49,        1'b0, 1'b0},
    '{32'd97,        1'b0, 1'b0},
    '{32'd7919,      1'b0, 1'b0},
    '{32'd1042441,   1'b0, 1'b0},
    // largest 16-bit prime, next fermat prime, largest 24-bit prime, first prime > 1e6
    '{32'd65521,     1'b0, 1'b0},
    '{32'd65537,     1'b0, 1'b0},
    '{32'd16777213,  1'b0, 1'b0},
    '{32'd1000003,   1'b0, 1'b0}
  };

  // 20 ns clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // low VALUE_WIDTH bits of a candidate take part in the test
  function automatic logic [63:0] tested_mask();
    if (VALUE_WIDTH >= 64) return '1;
    return (64'd1 << VALUE_WIDTH) - 64'd1;
  endfunction

  // trial division k = 2, 3, ... while k*k <= v, stopping at the first exact
  // divisor; tries returns how many divisors were looked at
  function automatic verdict_t primality_verdict(input logic [CAND_WIDTH-1:0] cand,
                                                 output int unsigned tries);
    logic [63:0] v;
    logic [63:0] k;
    verdict_t    r;
    v          = {32'b0, cand} & tested_mask();
    r.echo     = v[ECHO_WIDTH-1:0];
    r.is_prime = (v >= 64'(FIRST_DIVISOR));
    tries      = 0;
    k          = 64'(FIRST_DIVISOR);
    // k <= v / k is the overflow-free form of k*k <= v
    while (r.is_prime && k <= v / k) begin
      tries++;
      if (v % k == 64'd0) r.is_prime = 1'b0;
      k++;
    end
    return r;
  endfunction

  // random candidate kept within the search budget
  function automatic logic [CAND_WIDTH-1:0] draw_candidate();
    int unsigned           sel;
    int unsigned           w;
    int unsigned           p;
    int unsigned           tries;
    logic [CAND_WIDTH-1:0] c;
    verdict_t              dummy;
    do begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        // odd square; for a prime root the search ends right at the bound
        p = $urandom_range(1, 510) * 2 + 1;
        c = CAND_WIDTH'(p * p);
      end else begin
        // mostly narrow values, some up to the full width
        w = (sel < 65) ? $urandom_range(2, 16) : $urandom_range(17, 32);
        c = $urandom;
        if (w < 32) c = c & ((32'd1 << w) - 32'd1);
        // usually keep the top bit so the value really is w bits wide
        if ($urandom_range(0, 3) != 0) c[w-1] = 1'b1;
      end
      dummy = primality_verdict(c, tries);
    end while (tries > TRY_BUDGET);
    return c;
  endfunction

  // one line per mismatch, counted for the final verdict
  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got, input logic [31:0] cand);
    $display("[%0t] MISMATCH %s: expected %0h, got %0h (candidate %0h)",
             $realtime, what, want, got, cand);
    mismatch_count++;
  endtask

  // offer one candidate, with random idle cycles first, and record its
  // expected verdict once the transaction is taken
  task automatic push_candidate(input logic [CAND_WIDTH-1:0] cand, input verdict_t want);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.candidate <= cand;
    // ready is sampled at the edge, before any update from that edge lands
    do @(posedge clk); while (!in_ch.ready);
    pending_verdicts.push_back(want);
  endtask

  // hold off the sender until every pending verdict has come back
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // result side backpressure, redrawn every cycle
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // result checker: each result transaction against the oldest expectation
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result with nothing pending", 64'd0,
                        64'(out_ch.is_prime), out_ch.echo_value);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_ch.is_prime !== want.is_prime)
          report_mismatch("is_prime", 64'(want.is_prime), 64'(out_ch.is_prime),
                          want.echo);
        if (out_ch.echo_value !== want.echo)
          report_mismatch("echo_value", 64'(want.echo), 64'(out_ch.echo_value),
                          want.echo);
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    verdict_t              want;
    int unsigned           tries;
    logic [CAND_WIDTH-1:0] cand;

    // every dut input known from time zero
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.candidate = '0;
    out_ch.ready    = 1'b0;
    mismatch_count  = 0;
    cycle_count     = 0;
    src_idle_pct    = 11;
    snk_idle_pct    = 66;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: typed verdict where given, predictor otherwise
    for (int i = 0; i < N_DIRECTED; i++) begin
      want = primality_verdict(directed_rows[i].cand, tries);
      if (directed_rows[i].typed) want.is_prime = directed_rows[i].prime;
      push_candidate(directed_rows[i].cand, want);
    end
    wait_for_drain();

    // random part in three idling phases: sender light / receiver heavy,
    // then swapped, then no idling at all
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 11;
          snk_idle_pct = 66;
        end
        1: begin
          src_idle_pct = 66;
          snk_idle_pct = 11;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < RANDOM_ITEMS / PHASES + 1; i++) begin
        cand = draw_candidate();
        want = primality_verdict(cand, tries);
        push_candidate(cand, want);
      end
      // sender stays quiet until everything is back
      wait_for_drain();
    end

    // let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/ptd_pkg.sv
hdl/ptd_in_if.sv
hdl/ptd_out_if.sv
hdl/ptd_datapath.sv
hdl/ptd_ctrl.sv
hdl/prime_trial_division_test.sv
bench/tb_top.sv
